// ----- hdl/hdc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_pkg
// Shared widths, types and state encodings for the densest-cluster finder.
// ----------------------------------------------------------------------------
package hdc_pkg;

    localparam int MAX_BINS   = 4096;
    localparam int COUNT_W    = 24;
    localparam int IDX_W      = 12;
    localparam int BIN_CNT_W  = 13;
    localparam int FRAC_W     = 8;
    localparam int MEAN_W     = IDX_W + FRAC_W;
    localparam int TOTAL_W    = 36;
    localparam int WSUM_W     = 48;
    localparam int PROD_W     = IDX_W + COUNT_W;
    localparam int STEP_W     = $clog2(MEAN_W);

    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     group_start;
        logic [IDX_W-1:0]     group_end;
        logic [TOTAL_W-1:0]   total;
        logic [WSUM_W-1:0]    weighted;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        FS_RUN,
        FS_ABSORB,
        FS_CLOSE,
        FS_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_OUT
    } t_back_state;

endpackage
`default_nettype wire

// ----- hdl/hdc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_front
// Takes bins, finds separators one bin late, keeps open and best group sums,
// and queues the best group when the histogram ends.
// ----------------------------------------------------------------------------
module hdc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [hdc_pkg::COUNT_W-1:0]   i_bin_count,
    input  wire logic                          i_last_bin,
    input  wire hdc_pkg::t_q_status            i_q_status,
    output logic                               o_push,
    output hdc_pkg::t_job                      o_job
);
    import hdc_pkg::*;

    t_front_state          r_state, n_state;
    logic [COUNT_W-1:0]    r_held_count, n_held_count;
    logic                  r_held_valid, n_held_valid;
    logic [BIN_CNT_W-1:0]  r_bin_index, n_bin_index;
    logic                  r_group_open, n_group_open;
    logic [IDX_W-1:0]      r_open_start, n_open_start;
    logic [TOTAL_W-1:0]    r_open_total, n_open_total;
    logic [WSUM_W-1:0]     r_open_weighted, n_open_weighted;
    logic [IDX_W-1:0]      r_best_start, n_best_start;
    logic [IDX_W-1:0]      r_best_end, n_best_end;
    logic [TOTAL_W-1:0]    r_best_total, n_best_total;
    logic [WSUM_W-1:0]     r_best_weighted, n_best_weighted;

    logic                  accept;
    logic                  in_range;
    logic                  separator;
    logic [IDX_W-1:0]      held_idx;
    logic [IDX_W-1:0]      prev_idx;
    logic [PROD_W-1:0]     product;
    logic [IDX_W-1:0]      abs_start;
    logic [TOTAL_W-1:0]    abs_total;
    logic [WSUM_W-1:0]     abs_weighted;
    logic                  close_win;

    assign accept    = i_valid && !o_stall;
    assign in_range  = r_bin_index < BIN_CNT_W'(MAX_BINS);
    assign separator = (r_held_count == '0) && (i_bin_count == '0);
    assign held_idx  = r_bin_index[IDX_W-1:0] - IDX_W'(1);
    assign prev_idx  = r_bin_index[IDX_W-1:0] - IDX_W'(2);

    // held bin folded into the open group
    assign product      = PROD_W'(held_idx) * PROD_W'(r_held_count);
    assign abs_start    = r_group_open ? r_open_start : held_idx;
    assign abs_total    = (r_group_open ? r_open_total : '0) + TOTAL_W'(r_held_count);
    assign abs_weighted = (r_group_open ? r_open_weighted : '0) + WSUM_W'(product);

    // strictly larger keeps the first of equal totals
    assign close_win = r_group_open && (r_open_total > r_best_total);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_RUN:    if (accept && i_last_bin) n_state = FS_ABSORB;
            FS_ABSORB: n_state = FS_CLOSE;
            FS_CLOSE:  n_state = FS_PUSH;
            FS_PUSH:   if (!i_q_status.full) n_state = FS_RUN;
            default:   n_state = FS_RUN;
        endcase
    end

    always_comb begin
        o_stall = (r_state != FS_RUN);
        o_push  = (r_state == FS_PUSH) && !i_q_status.full;
    end

    always_comb begin
        n_held_count    = r_held_count;
        n_held_valid    = r_held_valid;
        n_bin_index     = r_bin_index;
        n_group_open    = r_group_open;
        n_open_start    = r_open_start;
        n_open_total    = r_open_total;
        n_open_weighted = r_open_weighted;
        n_best_start    = r_best_start;
        n_best_end      = r_best_end;
        n_best_total    = r_best_total;
        n_best_weighted = r_best_weighted;
        unique case (r_state)
            FS_RUN: begin
                if (accept && in_range) begin
                    if (r_held_valid) begin
                        if (separator) begin
                            if (close_win) begin
                                n_best_start    = r_open_start;
                                n_best_end      = prev_idx;
                                n_best_total    = r_open_total;
                                n_best_weighted = r_open_weighted;
                            end
                            n_group_open = 1'b0;
                        end else begin
                            n_group_open    = 1'b1;
                            n_open_start    = abs_start;
                            n_open_total    = abs_total;
                            n_open_weighted = abs_weighted;
                        end
                    end
                    n_held_count = i_bin_count;
                    n_held_valid = 1'b1;
                    n_bin_index  = r_bin_index + BIN_CNT_W'(1);
                end
            end
            FS_ABSORB: begin
                if (r_held_valid) begin
                    n_group_open    = 1'b1;
                    n_open_start    = abs_start;
                    n_open_total    = abs_total;
                    n_open_weighted = abs_weighted;
                end
            end
            FS_CLOSE: begin
                if (r_held_valid) begin
                    if (close_win) begin
                        n_best_start    = r_open_start;
                        n_best_end      = held_idx;
                        n_best_total    = r_open_total;
                        n_best_weighted = r_open_weighted;
                    end
                    n_group_open = 1'b0;
                end
            end
            FS_PUSH: begin
                if (!i_q_status.full) begin
                    n_held_count    = '0;
                    n_held_valid    = 1'b0;
                    n_bin_index     = '0;
                    n_group_open    = 1'b0;
                    n_open_start    = '0;
                    n_open_total    = '0;
                    n_open_weighted = '0;
                    n_best_start    = '0;
                    n_best_end      = '0;
                    n_best_total    = '0;
                    n_best_weighted = '0;
                end
            end
            default: ;
        endcase
    end

    // no positive group: every field goes out as zero
    always_comb begin
        o_job.found       = (r_best_total != '0);
        o_job.group_start = o_job.found ? r_best_start : '0;
        o_job.group_end   = o_job.found ? r_best_end : '0;
        o_job.total       = o_job.found ? r_best_total : '0;
        o_job.weighted    = o_job.found ? r_best_weighted : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= FS_RUN;
            r_held_count    <= '0;
            r_held_valid    <= 1'b0;
            r_bin_index     <= '0;
            r_group_open    <= 1'b0;
            r_open_start    <= '0;
            r_open_total    <= '0;
            r_open_weighted <= '0;
            r_best_start    <= '0;
            r_best_end      <= '0;
            r_best_total    <= '0;
            r_best_weighted <= '0;
        end else begin
            r_state         <= n_state;
            r_held_count    <= n_held_count;
            r_held_valid    <= n_held_valid;
            r_bin_index     <= n_bin_index;
            r_group_open    <= n_group_open;
            r_open_start    <= n_open_start;
            r_open_total    <= n_open_total;
            r_open_weighted <= n_open_weighted;
            r_best_start    <= n_best_start;
            r_best_end      <= n_best_end;
            r_best_total    <= n_best_total;
            r_best_weighted <= n_best_weighted;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/hdc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_queue
// Two-entry queue of finished groups between the front and the divider.
// ----------------------------------------------------------------------------
module hdc_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire hdc_pkg::t_job      i_job,
    input  wire logic               i_pop,
    output hdc_pkg::t_job           o_job,
    output hdc_pkg::t_q_status      o_status
);
    import hdc_pkg::*;

    t_job         r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic [1:0]   n_count;

    assign o_job           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 2'd1;
        if (i_pop && !i_push) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/hdc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_back
// Restoring divider for the Q.8 mean bin index, one quotient bit a cycle,
// and the output word register.
// ----------------------------------------------------------------------------
module hdc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hdc_pkg::t_job                 i_job,
    input  wire hdc_pkg::t_q_status            i_q_status,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_found,
    output logic [hdc_pkg::IDX_W-1:0]          o_group_start,
    output logic [hdc_pkg::IDX_W-1:0]          o_group_end,
    output logic [hdc_pkg::MEAN_W-1:0]         o_mean_index_q8,
    output logic [hdc_pkg::TOTAL_W-1:0]        o_group_total
);
    import hdc_pkg::*;

    t_back_state         r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    logic [TOTAL_W-1:0]  r_rem;
    logic [TOTAL_W-1:0]  r_div;
    logic [MEAN_W-1:0]   r_shift;
    logic                r_found;
    logic [IDX_W-1:0]    r_start;
    logic [IDX_W-1:0]    r_end;

    logic [TOTAL_W:0]    partial;
    logic [TOTAL_W:0]    diff;
    logic                ge;
    logic                last_step;

    // mean index < 2^IDX_W, so the dividend top bits start below the divisor
    assign partial   = {r_rem, r_shift[MEAN_W-1]};
    assign diff      = partial - {1'b0, r_div};
    assign ge        = (partial >= {1'b0, r_div});
    assign last_step = (r_step == STEP_W'(MEAN_W - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: if (!i_q_status.empty) n_state = BS_DIV;
            BS_DIV:  if (last_step) n_state = BS_OUT;
            BS_OUT:  if (!i_stall) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop           = (r_state == BS_IDLE) && !i_q_status.empty;
        o_valid         = (r_state == BS_OUT);
        o_found         = r_found;
        o_group_start   = r_start;
        o_group_end     = r_end;
        o_group_total   = r_div;
        o_mean_index_q8 = r_found ? r_shift : '0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem   <= i_job.weighted[WSUM_W-1:MEAN_W-FRAC_W];
            r_shift <= {i_job.weighted[MEAN_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            r_div   <= i_job.total;
            r_found <= i_job.found;
            r_start <= i_job.group_start;
            r_end   <= i_job.group_end;
        end else if (r_state == BS_DIV) begin
            r_rem   <= ge ? diff[TOTAL_W-1:0] : partial[TOTAL_W-1:0];
            r_shift <= {r_shift[MEAN_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_DIV) r_step <= last_step ? '0 : r_step + STEP_W'(1);
            else r_step <= '0;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/histogram_densest_cluster.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_densest_cluster
// Finds the densest group of adjacent nonzero bins in a streamed histogram.
//
// Input channel: one bin word per transfer (i_valid, o_stall), the final bin
// flagged by i_last_bin. Bins are taken one per cycle while o_stall is low;
// after the final bin the front holds o_stall high through its absorb, close
// and push states to close the group and queue it, longer only if both queue
// entries are still waiting on the divider.
// Output channel: one word per histogram (o_valid, i_stall) with start, end,
// total and Q.8 mean bin index. The divider makes one quotient bit a cycle.
// A finished word is held steady while i_stall is high; the front keeps
// accepting the next histogram meanwhile, up to two queued results.
// Reset (i_rst_n low, synchronous) clears all group sums and empties the
// queue; no output word is pending afterward. Bins past 4096 are dropped.
// ----------------------------------------------------------------------------
module histogram_densest_cluster (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [hdc_pkg::COUNT_W-1:0]   i_bin_count,
    input  wire logic                          i_last_bin,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_found,
    output logic [hdc_pkg::IDX_W-1:0]          o_group_start,
    output logic [hdc_pkg::IDX_W-1:0]          o_group_end,
    output logic [hdc_pkg::MEAN_W-1:0]         o_mean_index_q8,
    output logic [hdc_pkg::TOTAL_W-1:0]        o_group_total
);
    import hdc_pkg::*;

    t_q_status  q_status;
    t_job       push_job;
    t_job       head_job;
    logic       push;
    logic       pop;

    hdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_bin_count (i_bin_count),
        .i_last_bin  (i_last_bin),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job       (push_job)
    );

    hdc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    hdc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (head_job),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_found         (o_found),
        .o_group_start   (o_group_start),
        .o_group_end     (o_group_end),
        .o_mean_index_q8 (o_mean_index_q8),
        .o_group_total   (o_group_total)
    );

endmodule
`default_nettype wire
